@@ rtl/core/pett_pkg.sv @@
// shared types and constants for the periodic event timer table
`default_nettype none

package pett_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = IDX_W + 1;

    // field widths
    localparam int WORD_W  = 32;
    localparam int KIND_W  = 2;
    localparam int IN_W    = 5 * WORD_W;
    localparam int OUT_W   = 2 * WORD_W;

    // item kinds carried on tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    // one stored table entry
    typedef struct packed {
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] due;
        logic [WORD_W-1:0] count;
        logic [WORD_W-1:0] period;
        logic [WORD_W-1:0] param;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/periodic_event_timer_table.sv @@
// periodic event timer table: entry store, scan sequencer and output register
`default_nettype none

// A table of up to sixteen timed events keyed by unique 32-bit id, held in an
// entry memory with one read and one write port that a small sequencer walks
// one entry per cycle. An add or a clear item is accepted and then takes a full
// pass over the memory, which checks for a duplicate or finds the id; an add
// to a full table and a clear-all finish in the accept cycle. A tick takes one
// pass that marks every due entry and picks the lowest due id, then fires that
// entry and makes a further pass to find each next lowest id, until no marked
// entry is left; a firing waits while the output register is still full. Each
// pass is paced by the memory read port, one entry per cycle. Input is refused
// while an item is being worked on; a finished result waits in the output
// register and the next item can be taken meanwhile.
module periodic_event_timer_table (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input beat
    input  wire logic                       s_tvalid,
    output      logic                       s_tready,
    // event_id, event_time, repeat_count, period, param
    input  wire logic [pett_pkg::IN_W-1:0]  s_tdata,
    // kind
    input  wire logic [pett_pkg::KIND_W-1:0] s_tuser,
    // result beat
    output      logic                       m_tvalid,
    input  wire logic                       m_tready,
    // fired_id, fired_param
    output      logic [pett_pkg::OUT_W-1:0] m_tdata,
    output      logic                       m_tlast
);
    import pett_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIRE
    } state_t;

    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

    state_t                     state_reg;
    kind_t                      kind_reg;
    logic [WORD_W-1:0]          item_id_reg;
    logic [WORD_W-1:0]          item_time_reg;
    logic [WORD_W-1:0]          item_count_reg;
    logic [WORD_W-1:0]          item_period_reg;
    logic [WORD_W-1:0]          item_param_reg;

    logic [TABLE_ENTRIES-1:0]   valid_reg;
    logic [TABLE_ENTRIES-1:0]   due_mask_reg;
    logic [CNT_W-1:0]           due_cnt_reg;
    logic                       mark_reg;
    logic                       hit_reg;

    logic [CNT_W-1:0]           scan_reg;
    logic                       rd_vld_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    entry_t                     rd_entry_reg;

    logic                       best_found_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    entry_t                     best_entry_reg;

    logic                       m_tvalid_reg;
    logic [WORD_W-1:0]          out_id_reg;
    logic [WORD_W-1:0]          out_param_reg;
    logic                       out_last_reg;

    entry_t                     mem [TABLE_ENTRIES];

    logic [IDX_W-1:0]           rd_addr;
    logic                       issue;
    logic                       scan_done;
    logic                       rd_entry_valid;
    logic                       id_match;
    logic                       is_due;
    logic                       cand;
    logic                       better;
    logic                       out_free;
    logic                       free_found;
    logic [IDX_W-1:0]           free_idx;
    logic                       repeat_fire;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    entry_t                     mem_wdata;

    // scan control and per-entry compare unit
    always_comb
    begin
        rd_addr        = scan_reg[IDX_W-1:0];
        issue          = (state_reg == ST_SCAN) && (scan_reg != SCAN_END);
        scan_done      = (state_reg == ST_SCAN) && !issue && !rd_vld_reg;
        rd_entry_valid = valid_reg[rd_idx_reg];
        id_match       = rd_entry_valid && (rd_entry_reg.id == item_id_reg);
        is_due         = rd_entry_valid && (rd_entry_reg.due < item_time_reg);
        cand           = mark_reg ? is_due : due_mask_reg[rd_idx_reg];
        better         = cand && (!best_found_reg || (rd_entry_reg.id < best_entry_reg.id));
        out_free       = !m_tvalid_reg || m_tready;
        repeat_fire    = best_entry_reg.count > WORD_W'(1);
    end

    // lowest free slot for an add
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // memory write: new entry on add, reschedule on a repeat firing
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = best_idx_reg;
        mem_wdata = best_entry_reg;
        if (state_reg == ST_FIRE)
        begin
            mem_we           = out_free && repeat_fire;
            mem_wdata.due    = item_time_reg + best_entry_reg.period;
            mem_wdata.count  = best_entry_reg.count - WORD_W'(1);
        end
        else if (scan_done && (kind_reg == KIND_ADD))
        begin
            mem_we           = !hit_reg && free_found;
            mem_waddr        = free_idx;
            mem_wdata.id     = item_id_reg;
            mem_wdata.due    = item_time_reg;
            mem_wdata.count  = item_count_reg;
            mem_wdata.period = item_period_reg;
            mem_wdata.param  = item_param_reg;
        end
    end

    // entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // sequencer, table flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kind_reg        <= KIND_ADD;
            item_id_reg     <= '0;
            item_time_reg   <= '0;
            item_count_reg  <= '0;
            item_period_reg <= '0;
            item_param_reg  <= '0;
            valid_reg       <= '0;
            due_mask_reg    <= '0;
            due_cnt_reg     <= '0;
            mark_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            scan_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            best_found_reg  <= 1'b0;
            best_idx_reg    <= '0;
            best_entry_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
            out_id_reg      <= '0;
            out_param_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            // read pipeline follows the scan counter
            rd_vld_reg <= issue;
            rd_idx_reg <= rd_addr;

            // result register: loaded by a firing, emptied once taken
            if ((state_reg == ST_FIRE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg        <= kind_t'(s_tuser);
                        item_id_reg     <= s_tdata[WORD_W-1:0];
                        item_time_reg   <= s_tdata[2*WORD_W-1:WORD_W];
                        item_count_reg  <= s_tdata[3*WORD_W-1:2*WORD_W];
                        item_period_reg <= s_tdata[4*WORD_W-1:3*WORD_W];
                        item_param_reg  <= s_tdata[5*WORD_W-1:4*WORD_W];
                        scan_reg        <= '0;
                        best_found_reg  <= 1'b0;
                        hit_reg         <= 1'b0;
                        unique case (kind_t'(s_tuser))
                            KIND_ADD:
                            begin
                                if (!(&valid_reg))
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                if (s_tdata[WORD_W-1:0] == '0)
                                begin
                                    valid_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            KIND_TICK:
                            begin
                                state_reg    <= ST_SCAN;
                                mark_reg     <= 1'b1;
                                due_mask_reg <= '0;
                                due_cnt_reg  <= '0;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    if (issue)
                    begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                    // look at the entry read last cycle
                    if (rd_vld_reg)
                    begin
                        unique case (kind_reg)
                            KIND_ADD:
                            begin
                                if (id_match)
                                begin
                                    hit_reg <= 1'b1;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                if (id_match)
                                begin
                                    valid_reg[rd_idx_reg] <= 1'b0;
                                end
                            end
                            KIND_TICK:
                            begin
                                if (mark_reg && is_due)
                                begin
                                    due_mask_reg[rd_idx_reg] <= 1'b1;
                                    due_cnt_reg              <= due_cnt_reg + CNT_W'(1);
                                end
                                if (better)
                                begin
                                    best_found_reg <= 1'b1;
                                    best_idx_reg   <= rd_idx_reg;
                                    best_entry_reg <= rd_entry_reg;
                                end
                            end
                            default:
                            begin
                                hit_reg <= hit_reg;
                            end
                        endcase
                    end
                    // end of the pass
                    if (scan_done)
                    begin
                        mark_reg <= 1'b0;
                        if ((kind_reg == KIND_ADD) && !hit_reg && free_found)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                        end
                        if ((kind_reg == KIND_TICK) && best_found_reg)
                        begin
                            state_reg <= ST_FIRE;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_FIRE:
                begin
                    if (out_free)
                    begin
                        out_id_reg                 <= best_entry_reg.id;
                        out_param_reg              <= best_entry_reg.param;
                        out_last_reg               <= (due_cnt_reg == CNT_W'(1));
                        due_mask_reg[best_idx_reg] <= 1'b0;
                        due_cnt_reg                <= due_cnt_reg - CNT_W'(1);
                        if (!repeat_fire)
                        begin
                            valid_reg[best_idx_reg] <= 1'b0;
                        end
                        // search the next lowest due id, or finish
                        scan_reg       <= '0;
                        best_found_reg <= 1'b0;
                        if (due_cnt_reg == CNT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_param_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // pending count always matches the due marks
    assert property (@(posedge clk) disable iff (!rst_n)
        due_cnt_reg == CNT_W'($countones(due_mask_reg)))
        else $error("due count out of step with due marks");

    // a firing entry is still marked due and still in the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIRE) |-> (due_mask_reg[best_idx_reg] && valid_reg[best_idx_reg]))
        else $error("firing an entry that is not due or not stored");

    // a tick pass that ends with marks pending must have picked an entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (scan_done && (kind_reg == KIND_TICK) && (due_cnt_reg != '0)) |-> best_found_reg)
        else $error("due entries left but none selected");
`endif

endmodule

`default_nettype wire
